[rtl/alsl_pkg.sv]
// Package for the allow list with strike lockout block.
// Holds field widths, operation codes, default table depths and the
// token structs that travel along the cell chains. No dependencies.
`default_nettype none

package alsl_pkg;

  localparam int ALLOW_DEPTH_DEF  = 64;
  localparam int STRIKE_DEPTH_DEF = 32;

  localparam int ID_W  = 32;
  localparam int OP_W  = 2;
  localparam int CNT_W = 8;

  localparam logic [CNT_W-1:0] CNT_MAX   = 8'hFF;
  localparam logic [CNT_W-1:0] CNT_FIRST = 8'd1;
  localparam logic [CNT_W-1:0] THR_RESET = 8'd3;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

  typedef struct packed {
    logic            v;
    logic [ID_W-1:0] key;
    logic            hit;
  } atok_t;

  typedef struct packed {
    logic            v;
    logic [ID_W-1:0] key;
    logic            hit;
    logic            lock;
  } stok_t;

endpackage

`default_nettype wire

[rtl/alsl_acell.sv]
// One allow table cell: holds one identifier and compares it against
// the search token passing by. Depends on alsl_pkg.
`default_nettype none

module alsl_acell import alsl_pkg::*; #(
  parameter int IDX = 0,
  parameter int UW  = 7
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [UW-1:0]   used,
  input  wire logic            wr_en,
  input  wire logic [ID_W-1:0] wr_id,
  input  wire atok_t           tok_in,
  output atok_t                tok_out
);

  logic [ID_W-1:0] id_r;
  atok_t           tok_r;
  logic            occ;
  logic            match;

  assign occ   = UW'(IDX) < used;
  assign match = tok_in.v & occ & (id_r == tok_in.key);

  always_ff @(posedge clk) begin
    if (wr_en && (used == UW'(IDX))) begin
      id_r <= wr_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
    end else begin
      tok_r.v <= tok_in.v;
    end
    tok_r.key <= tok_in.key;
    tok_r.hit <= tok_in.hit | match;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

[rtl/alsl_scell.sv]
// One strike table cell: holds an identifier and its saturating count,
// bumps it when a report or traced query token matches. Uses alsl_pkg.
`default_nettype none

module alsl_scell import alsl_pkg::*; #(
  parameter int IDX = 0,
  parameter int UW  = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [UW-1:0]    used,
  input  wire logic [CNT_W-1:0] thr,
  input  wire logic             new_en,
  input  wire logic [ID_W-1:0]  new_id,
  input  wire stok_t            tok_in,
  output stok_t                 tok_out
);

  logic [ID_W-1:0]  id_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_inc;
  stok_t            tok_r;
  logic             occ;
  logic             upd;

  assign occ     = UW'(IDX) < used;
  assign upd     = tok_in.v & ~tok_in.hit & occ & (id_r == tok_in.key);
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_FIRST;

  always_ff @(posedge clk) begin
    if (new_en && (used == UW'(IDX))) begin
      id_r  <= new_id;
      cnt_r <= CNT_FIRST;
    end else if (upd) begin
      cnt_r <= cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.v <= 1'b0;
    end else begin
      tok_r.v <= tok_in.v;
    end
    tok_r.key  <= tok_in.key;
    tok_r.hit  <= tok_in.hit | upd;
    tok_r.lock <= tok_in.hit ? tok_in.lock : (upd & (cnt_inc >= thr));
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

[rtl/allow_list_with_strike_lockout.sv]
// Allow list with strike lockout, top level. Instantiates the allow cell
// chain (alsl_acell) and the strike cell chain (alsl_scell); uses alsl_pkg.
// One transaction at a time. An add, a query while locked out or an unused
// operation code goes straight to the done state. An untraced query sends
// a search token down the allow chain, one cell per cycle. A report or a
// traced query sends a token down the strike chain. A new transaction is
// taken while a finished result still waits on the output register.
`default_nettype none

module allow_list_with_strike_lockout import alsl_pkg::*; #(
  parameter int ALLOW_DEPTH  = ALLOW_DEPTH_DEF,
  parameter int STRIKE_DEPTH = STRIKE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [OP_W-1:0]  in_operation,
  input  wire logic [ID_W-1:0]  in_ident,
  input  wire logic             in_traced,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_allowed,
  output logic                  out_table_full,
  output logic                  out_locked_out
);

  localparam int AUW = $clog2(ALLOW_DEPTH + 1);
  localparam int SUW = $clog2(STRIKE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ASCAN = 4'b0010,
    ST_SSCAN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] thr_r;
  logic [AUW-1:0]   a_used_r, a_used_nxt;
  logic [SUW-1:0]   s_used_r, s_used_nxt;
  logic             lockout_r, lockout_nxt;
  logic             res_allowed_r, res_allowed_nxt;
  logic             res_full_r, res_full_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_allowed_r, out_table_full_r, out_locked_out_r;

  atok_t a_tok [ALLOW_DEPTH+1];
  stok_t s_tok [STRIKE_DEPTH+1];

  logic acc;
  logic is_add, is_query, is_report;
  logic a_full, s_full;
  logic a_wr, s_launch, a_launch;
  logic a_end, s_end, s_new, out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid) begin
      thr_r <= cfg_data;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid & in_ready;
  assign is_add    = (in_operation == OP_ADD);
  assign is_query  = (in_operation == OP_QUERY);
  assign is_report = (in_operation == OP_REPORT);
  assign a_full    = (a_used_r == AUW'(ALLOW_DEPTH));
  assign s_full    = (s_used_r == SUW'(STRIKE_DEPTH));

  assign a_wr     = acc & is_add & ~a_full;
  assign a_launch = acc & is_query & ~lockout_r & ~in_traced;
  assign s_launch = acc & (is_report | (is_query & ~lockout_r & in_traced));

  assign a_tok[0] = '{v: a_launch, key: in_ident, hit: 1'b0};
  assign s_tok[0] = '{v: s_launch, key: in_ident, hit: 1'b0, lock: 1'b0};

  assign a_end = (state_r == ST_ASCAN) & a_tok[ALLOW_DEPTH].v;
  assign s_end = (state_r == ST_SSCAN) & s_tok[STRIKE_DEPTH].v;
  assign s_new = s_end & ~s_tok[STRIKE_DEPTH].hit & ~s_full;

  for (genvar i = 0; i < ALLOW_DEPTH; i++) begin : g_acell
    alsl_acell #(
      .IDX (i),
      .UW  (AUW)
    ) u_acell (
      .clk     (clk),
      .rst_n   (rst_n),
      .used    (a_used_r),
      .wr_en   (a_wr),
      .wr_id   (in_ident),
      .tok_in  (a_tok[i]),
      .tok_out (a_tok[i+1])
    );
  end

  for (genvar i = 0; i < STRIKE_DEPTH; i++) begin : g_scell
    alsl_scell #(
      .IDX (i),
      .UW  (SUW)
    ) u_scell (
      .clk     (clk),
      .rst_n   (rst_n),
      .used    (s_used_r),
      .thr     (thr_r),
      .new_en  (s_new),
      .new_id  (s_tok[STRIKE_DEPTH].key),
      .tok_in  (s_tok[i]),
      .tok_out (s_tok[i+1])
    );
  end

  assign out_load = (state_r == ST_DONE) & (~out_valid_r | out_ready);

  always_comb begin
    state_nxt       = state_r;
    a_used_nxt      = a_used_r;
    s_used_nxt      = s_used_r;
    lockout_nxt     = lockout_r;
    res_allowed_nxt = res_allowed_r;
    res_full_nxt    = res_full_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          res_allowed_nxt = 1'b0;
          res_full_nxt    = is_add & a_full;
          if (a_wr) begin
            a_used_nxt = a_used_r + AUW'(1);
          end
          if (a_launch) begin
            state_nxt = ST_ASCAN;
          end else if (s_launch) begin
            state_nxt = ST_SSCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ASCAN: begin
        if (a_end) begin
          res_allowed_nxt = a_tok[ALLOW_DEPTH].hit;
          state_nxt       = ST_DONE;
        end
      end
      ST_SSCAN: begin
        if (s_end) begin
          if (s_tok[STRIKE_DEPTH].hit && s_tok[STRIKE_DEPTH].lock) begin
            lockout_nxt = 1'b1;
          end
          if (s_new) begin
            s_used_nxt = s_used_r + SUW'(1);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      a_used_r    <= '0;
      s_used_r    <= '0;
      lockout_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_used_r    <= a_used_nxt;
      s_used_r    <= s_used_nxt;
      lockout_r   <= lockout_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_allowed_r <= res_allowed_nxt;
    res_full_r    <= res_full_nxt;
    if (out_load) begin
      out_allowed_r    <= res_allowed_r;
      out_table_full_r <= res_full_r;
      out_locked_out_r <= lockout_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_allowed    = out_allowed_r;
  assign out_table_full = out_table_full_r;
  assign out_locked_out = out_locked_out_r;

endmodule

`default_nettype wire
